>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled during reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked with a non-overlapping consequent (|=>)
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/itl_pkg.sv
// ----------------------------------------------------------------------------
// itl_pkg
// Shared types and constants for the interpolating table lookup.
// ----------------------------------------------------------------------------
package itl_pkg;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam int DATA_W = 32;

    // Divider request: unsigned dividend/divisor, 64/33 bit
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/itl_div.sv
// ----------------------------------------------------------------------------
// itl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itl_pkg::t_div_req  i_req,
    output itl_pkg::t_div_rsp  o_rsp
);

    logic [63:0] r_quo, n_quo;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] w_trial;
    logic [33:0] w_sub;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[32:0], r_quo[63]};
        w_sub   = w_trial - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[33]) begin
                n_rem = w_sub;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> rtl/interpolating_table_lookup_top.sv
// ----------------------------------------------------------------------------
// interpolating_table_lookup_top
// Node table in two synchronous memories; lookup by binary search over the
// stored edges, then linear interpolation with a serial divider.
//
//   channel | handshake          | payload
//   input   | i_valid / o_stall  | i_cmd i_node_index i_energy i_node_value
//   output  | o_valid / i_stall  | o_loss_value o_clamped
//   config  | i_cfg_we           | i_cfg_data
//
// Lookup: clamp check on the first and last edge; an interior energy takes a
// binary search, one memory read per search step, then the bit-serial divider.
// One item in flight at a time.
// Reset is synchronous; memories are not cleared. A held result stalls input.
// ----------------------------------------------------------------------------
module interpolating_table_lookup_top #(
    parameter int MAX_NODES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [0:0]         i_cmd,
    input  logic [7:0]         i_node_index,
    input  logic [31:0]        i_energy,
    input  logic signed [31:0] i_node_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_loss_value,
    output logic               o_clamped,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data
);

    localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CW = AW + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD0   = 9'b000000010,
        S_RDN   = 9'b000000100,
        S_CHK   = 9'b000001000,
        S_SRCH  = 9'b000010000,
        S_RDLO  = 9'b000100000,
        S_RDHI  = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    logic [31:0]        r_edge_mem [MAX_NODES];
    logic signed [31:0] r_val_mem  [MAX_NODES];
    logic [31:0]        r_edge_rd;
    logic signed [31:0] r_val_rd;
    logic [AW-1:0]      w_raddr;

    t_state             r_state, n_state;
    logic [8:0]         r_cfg;
    logic [CW-1:0]      w_n;
    logic [31:0]        r_e;
    logic [31:0]        r_x0;
    logic signed [31:0] r_y0;
    logic [CW-1:0]      r_lo, r_hi, r_mid;
    logic               r_ph;
    logic               r_ovalid;
    logic signed [31:0] r_oval;
    logic               r_oclamp;
    logic               r_neg;
    itl_pkg::t_div_req  w_dreq;
    itl_pkg::t_div_rsp  w_drsp;
    logic [32:0]        r_w;
    logic [31:0]        r_dx;
    logic [31:0]        r_mag;
    logic [63:0]        r_prod;
    logic [1:0]         r_dstep;
    logic signed [32:0] w_dy;
    logic               w_acc;

    // active node count, clamped to 2..MAX_NODES
    always_comb begin
        if (r_cfg < 9'd2) w_n = CW'(2);
        else if ({23'd0, r_cfg} > 32'(MAX_NODES)) w_n = CW'(MAX_NODES);
        else w_n = CW'(r_cfg);
    end

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;

    always_comb begin
        case (r_state)
            S_RD0:   w_raddr = '0;
            S_RDN:   w_raddr = AW'(w_n - CW'(1));
            S_SRCH:  w_raddr = AW'(r_mid);
            S_RDLO:  w_raddr = AW'(r_lo);
            S_RDHI:  w_raddr = AW'(r_lo + CW'(1));
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_cmd == itl_pkg::CMD_WRITE &&
            {24'd0, i_node_index} < 32'(MAX_NODES)) begin
            r_edge_mem[AW'(i_node_index)] <= i_energy;
            r_val_mem[AW'(i_node_index)]  <= i_node_value;
        end
        r_edge_rd <= r_edge_mem[w_raddr];
        r_val_rd  <= r_val_mem[w_raddr];
    end

    assign w_dy = 33'(r_val_rd) - 33'(r_y0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc && i_cmd == itl_pkg::CMD_LOOKUP) n_state = S_RD0;
            S_RD0:  n_state = S_RDN;
            S_RDN:  n_state = S_CHK;
            S_CHK:  n_state = S_SRCH;
            S_SRCH: n_state = S_SRCH;
            S_RDLO: n_state = S_RDHI;
            S_RDHI: n_state = S_DIV;
            S_DIV:  n_state = S_DIV;
            S_OUT:  n_state = S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_dreq.start = (r_state == S_DIV) && (r_dstep == 2'd2);
    assign w_dreq.num   = r_prod;
    assign w_dreq.den   = r_w;

    itl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= 9'd2;
            r_ovalid <= 1'b0;
            r_ph     <= 1'b0;
            r_dstep  <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_e <= i_energy;
                    r_state <= n_state;
                end
                S_RD0: r_state <= S_RDN;
                S_RDN: begin
                    // edge0/value0 data arrive now
                    if (r_e <= r_edge_rd) begin
                        r_oval <= r_val_rd; r_oclamp <= 1'b1;
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_e >= r_edge_rd) begin
                        r_oval <= r_val_rd; r_oclamp <= 1'b1;
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_lo <= '0;
                        r_hi <= w_n - CW'(1);
                        r_mid <= (w_n - CW'(1)) >> 1;
                        r_ph <= 1'b0;
                        if (w_n == CW'(2)) r_state <= S_RDLO;
                        else r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    // phase 0 issues read of mid, phase 1 consumes it
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_edge_rd <= r_e) begin
                            r_lo <= r_mid;
                            r_mid <= (r_mid + r_hi) >> 1;
                            if (r_hi - r_mid <= CW'(1)) r_state <= S_RDLO;
                        end else begin
                            r_hi <= r_mid;
                            r_mid <= (r_lo + r_mid) >> 1;
                            if (r_mid - r_lo <= CW'(1)) r_state <= S_RDLO;
                        end
                    end
                end
                S_RDLO: r_state <= S_RDHI;
                S_RDHI: begin
                    r_x0 <= r_edge_rd;
                    r_y0 <= r_val_rd;
                    r_dstep <= 2'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    case (r_dstep)
                        2'd0: begin
                            // hi node data valid now
                            if (r_edge_rd <= r_x0) begin
                                r_oval <= r_y0; r_oclamp <= 1'b0;
                                r_ovalid <= 1'b1; r_state <= S_IDLE;
                            end else begin
                                r_w <= {1'b0, r_edge_rd} - {1'b0, r_x0};
                                if (r_e <= r_x0) r_dx <= '0;
                                else if (r_e >= r_edge_rd) r_dx <= r_edge_rd - r_x0;
                                else r_dx <= r_e - r_x0;
                                r_neg <= w_dy[32];
                                r_mag <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
                                r_dstep <= 2'd1;
                            end
                        end
                        2'd1: begin
                            r_prod <= 64'(r_dx) * 64'(r_mag);
                            r_dstep <= 2'd2;
                        end
                        2'd2: r_dstep <= 2'd3;
                        default: begin
                            if (w_drsp.done) begin
                                r_oval <= r_neg ? r_y0 - w_drsp.quo[31:0]
                                                : r_y0 + w_drsp.quo[31:0];
                                r_oclamp <= 1'b0;
                                r_ovalid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_loss_value = r_oval;
    assign o_clamped    = r_oclamp;

endmodule

>>> rtl/itl_checker.sv
// ----------------------------------------------------------------------------
// itl_checker
// Port-level checks for the interpolating table lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_loss_value,
    input logic        o_clamped
);

    `CHK_IMPLY(a_out_blocks_in, i_clk, i_rst_n, o_valid, o_stall, "input taken while result held")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_loss_value), "stalled result changed")
    `CHK_NEXT(a_one_result, i_clk, i_rst_n, o_valid && !i_stall, !o_valid, "result repeated")
    `CHK_NEXT(a_clamp_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_clamped), "stalled flag changed")

endmodule

bind interpolating_table_lookup_top itl_checker u_itl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_loss_value (o_loss_value),
    .o_clamped    (o_clamped)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interpolating_table_lookup_top. A table-driven
// directed part runs first, then random phases. Each phase sets the node
// count, loads a table and sends lookups. Any node rewrites are mixed in with
// the lookups. A local table model predicts each untyped lookup result, and
// output transfers are checked in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [0:0]         cmd;
        logic [7:0]         idx;
        logic [31:0]        energy;
        logic signed [31:0] value;
        bit                 typed;
        logic signed [31:0] exp_val;
        bit                 exp_clamp;
    } t_row;

    typedef struct {
        logic signed [31:0] val;
        bit                 clamp;
    } t_loss;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [0:0]         i_cmd;
    logic [7:0]         i_node_index;
    logic [31:0]        i_energy;
    logic signed [31:0] i_node_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_loss_value;
    logic               o_clamped;
    logic               i_cfg_we;
    logic [8:0]         i_cfg_data;

    logic [31:0]        knot_energy [256];
    logic signed [31:0] knot_value [256];
    logic [8:0]         node_count_reg;
    t_loss              pending_losses [$];
    int                 error_count;
    bit                 no_idle;
    int                 quiet_cycles;

    interpolating_table_lookup_top #(.MAX_NODES(256)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_node_index(i_node_index),
        .i_energy(i_energy), .i_node_value(i_node_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_loss_value(o_loss_value), .o_clamped(o_clamped),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_nodes();
        int n;
        n = node_count_reg;
        if (n < 2) n = 2;
        if (n > 256) n = 256;
        return n;
    endfunction

    function automatic t_loss interpolate_loss(logic [31:0] e);
        t_loss r;
        int n, lo, hi, mid;
        logic [31:0] x0, x1;
        longint y0, y1, dy, y;
        bit [63:0] w, dx, mag, q;
        n = active_nodes();
        r.clamp = 1;
        if (e <= knot_energy[0]) begin
            r.val = knot_value[0];
            return r;
        end
        if (e >= knot_energy[n-1]) begin
            r.val = knot_value[n-1];
            return r;
        end
        r.clamp = 0;
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (knot_energy[mid] <= e) lo = mid;
            else hi = mid;
        end
        x0 = knot_energy[lo];
        x1 = knot_energy[lo+1];
        y0 = knot_value[lo];
        y1 = knot_value[lo+1];
        if (x1 <= x0) begin
            r.val = y0[31:0];
            return r;
        end
        w = {32'd0, x1} - {32'd0, x0};
        if (e <= x0) dx = 0;
        else if (e >= x1) dx = w;
        else dx = {32'd0, e} - {32'd0, x0};
        dy = y1 - y0;
        mag = (dy < 0) ? -dy : dy;
        q = (dx * mag) / w;
        y = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
        r.val = y[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // One input transfer; the model is updated at acceptance.
    task automatic send_item(logic [0:0] cmd, logic [7:0] idx, logic [31:0] e,
                             logic signed [31:0] v, bit typed = 0,
                             logic signed [31:0] xv = 0, bit xc = 0);
        int gap;
        t_loss r;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_node_index <= idx;
        i_energy     <= e;
        i_node_value <= v;
        do @(posedge i_clk); while (o_stall);
        if (cmd == itl_pkg::CMD_WRITE) begin
            knot_energy[idx] = e;
            knot_value[idx]  = v;
        end else begin
            r = interpolate_loss(e);
            if (typed) begin
                r.val = xv;
                r.clamp = xc;
            end
            pending_losses.insert(pending_losses.size(), r);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_losses.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic set_node_count(logic [8:0] n);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_count_reg = n;
    endtask

    task automatic load_table(int n, int style);
        logic [31:0] e;
        e = (style == 2) ? 32'd0 : $urandom_range(0, 32'h0010_0000);
        for (int k = 0; k < n; k++) begin
            if (style == 1) e = $urandom;
            else if (style != 2 || k == n - 1) e = e + $urandom_range(1, 32'h0100_0000 / n);
            if (style == 3 && $urandom_range(0, 3) == 0) e = e;
            else if (style == 3) e = e + 1;
            send_item(itl_pkg::CMD_WRITE, k[7:0],
                      (style == 2 && k == n - 1) ? 32'hFFFF_FFFF : e, $urandom);
        end
    endtask

    task automatic run_lookups(int count, int n);
        int pick;
        logic [31:0] a, b, e;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (k == count / 2) drain();
            if (pick < 10) begin
                send_item(itl_pkg::CMD_WRITE, 8'($urandom), $urandom, $urandom);
            end else if (pick < 15) begin
                pick = $urandom_range(0, n - 1);
                send_item(itl_pkg::CMD_WRITE, pick[7:0], knot_energy[pick], $urandom);
            end else if (pick < 85) begin
                pick = $urandom_range(0, n - 2);
                a = knot_energy[pick];
                b = knot_energy[pick+1];
                e = (b > a) ? a + ($urandom % (b - a)) : a;
                send_item(itl_pkg::CMD_LOOKUP, 8'($urandom), e, $urandom);
            end else if (pick < 92) begin
                pick = $urandom_range(0, 3);
                e = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                    (pick == 2) ? knot_energy[0] : knot_energy[n-1];
                send_item(itl_pkg::CMD_LOOKUP, 8'($urandom), e, $urandom);
            end else begin
                send_item(itl_pkg::CMD_LOOKUP, 8'($urandom), $urandom, $urandom);
            end
        end
    endtask

    t_row directed [] = '{
        '{itl_pkg::CMD_WRITE,  8'd0,  32'h0001_0000, 32'sh0005_0000, 0, 0, 0},
        '{itl_pkg::CMD_WRITE,  8'd1,  32'h0003_0000, -32'sh0003_0000, 0, 0, 0},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0000_0000, 0, 1, 32'sh0005_0000, 1},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0001_0000, 0, 1, 32'sh0005_0000, 1},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0003_0000, 0, 1, -32'sh0003_0000, 1},
        '{itl_pkg::CMD_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
          -32'sh0003_0000, 1},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0002_0000, 0, 0, 0, 0},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0001_0001, 0, 0, 0, 0},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0002_FFFF, 0, 0, 0, 0},
        '{itl_pkg::CMD_WRITE,  8'hFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0},
        '{itl_pkg::CMD_WRITE,  8'd0,  32'h0000_0000, 32'sh7FFF_FFFF, 0, 0, 0},
        '{itl_pkg::CMD_WRITE,  8'd1,  32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0000_0000, 0, 1, 32'sh7FFF_FFFF, 1},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'hFFFF_FFFF, 0, 1, 32'h8000_0000, 1},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h8000_0000, 0, 0, 0, 0},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0000_0001, 0, 0, 0, 0},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'hFFFF_FFFE, 0, 0, 0, 0},
        '{itl_pkg::CMD_WRITE,  8'd1,  32'h0000_0000, 32'sh0001_0000, 0, 0, 0},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h0000_0000, 0, 1, 32'sh7FFF_FFFF, 1},
        '{itl_pkg::CMD_LOOKUP, 8'd0,  32'h1234_5678, 0, 1, 32'sh0001_0000, 1}
    };

    int phase_counts [] = '{511, 0, 1, 2, 3, 17, 5, 9};

    initial begin
        int n;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = itl_pkg::CMD_WRITE;
        i_node_index = '0;
        i_energy     = '0;
        i_node_value = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        error_count  = 0;
        no_idle      = 0;
        node_count_reg = 9'd2;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_item(directed[k].cmd, directed[k].idx, directed[k].energy,
                      directed[k].value, directed[k].typed,
                      directed[k].exp_val, directed[k].exp_clamp);
        drain();

        // first phase writes all 256 nodes, so later reads always hit written entries
        for (int p = 0; p < phase_counts.size(); p++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            set_node_count(9'(phase_counts[p]));
            n = active_nodes();
            load_table(p == 0 ? 256 : n, (p == 0) ? 0 : $urandom_range(0, 4) % 4);
            run_lookups(25, n);
            drain();
        end
        for (int p = 0; p < 3; p++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            set_node_count(9'($urandom_range(2, 40)));
            n = active_nodes();
            load_table(n, $urandom_range(0, 3));
            run_lookups(20, n);
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int k;
        t_loss r;
        i_stall = 1'b0;
        forever begin
            k = no_idle ? 0 : $urandom_range(0, 4);
            if (k > 0) begin
                i_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            if (pending_losses.size() == 0) begin
                report_mismatch("result transfer with no lookup pending");
            end else begin
                r = pending_losses.pop_front();
                if (o_loss_value !== r.val)
                    report_mismatch($sformatf("loss_value %h, expected %h",
                                              o_loss_value, r.val));
                if (o_clamped !== r.clamp)
                    report_mismatch($sformatf("clamped %b, expected %b",
                                              o_clamped, r.clamp));
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

>>> files.f
+incdir+rtl
rtl/itl_pkg.sv
rtl/itl_div.sv
rtl/interpolating_table_lookup_top.sv
rtl/itl_checker.sv
test/tb.sv
